// ----- sv/lpg_pkg.sv -----
// line pixel generator package: coordinate width, transaction structs,
// command codes and configuration register indexes
// no dependencies
package lpg_pkg;

    localparam int COORD_BITS = 12;
    localparam int REM_BITS = COORD_BITS + 2;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [COORD_BITS-1:0] SCREEN_WIDTH_RESET = COORD_BITS'(640);
    localparam logic [COORD_BITS-1:0] SCREEN_HEIGHT_RESET = COORD_BITS'(480);

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_ADVANCE = 1'b1
    } t_kind;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SCREEN_WIDTH = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic kind;
        logic signed [COORD_BITS-1:0] x_first;
        logic signed [COORD_BITS-1:0] y_first;
        logic signed [COORD_BITS-1:0] x_second;
        logic signed [COORD_BITS-1:0] y_second;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic off_screen;
        logic last;
    } t_out_item;

    // line setup as handed from front to back
    typedef struct packed {
        t_kind kind;
        logic major_is_y;
        logic signed [COORD_BITS-1:0] major_begin;
        logic signed [COORD_BITS-1:0] major_end;
        logic signed [COORD_BITS-1:0] minor_begin;
        logic [COORD_BITS-1:0] major_len;
        logic [COORD_BITS-1:0] minor_len;
        logic minor_neg;
    } t_cmd;

endpackage

// ----- sv/lpg_front.sv -----
// front end: classifies an input transaction and works out the line setup
// depends on lpg_pkg
module lpg_front (
    input  lpg_pkg::t_in_item i_item,
    output lpg_pkg::t_cmd     o_cmd
);
    import lpg_pkg::*;

    logic signed [COORD_BITS:0] w_dx;
    logic signed [COORD_BITS:0] w_dy;
    logic [COORD_BITS-1:0] w_adx;
    logic [COORD_BITS-1:0] w_ady;
    logic w_major_is_y;
    logic w_fwd;

    assign w_dx = {i_item.x_second[COORD_BITS-1], i_item.x_second}
                - {i_item.x_first[COORD_BITS-1], i_item.x_first};
    assign w_dy = {i_item.y_second[COORD_BITS-1], i_item.y_second}
                - {i_item.y_first[COORD_BITS-1], i_item.y_first};
    assign w_adx = w_dx[COORD_BITS] ? COORD_BITS'(-w_dx) : COORD_BITS'(w_dx);
    assign w_ady = w_dy[COORD_BITS] ? COORD_BITS'(-w_dy) : COORD_BITS'(w_dy);
    assign w_major_is_y = (w_ady >= w_adx);
    assign w_fwd = w_major_is_y ? !w_dy[COORD_BITS] : !w_dx[COORD_BITS];

    always_comb begin
        o_cmd.kind = t_kind'(i_item.kind);
        o_cmd.major_is_y = w_major_is_y;
        if (w_major_is_y) begin
            o_cmd.major_begin = w_fwd ? i_item.y_first : i_item.y_second;
            o_cmd.major_end = w_fwd ? i_item.y_second : i_item.y_first;
            o_cmd.minor_begin = w_fwd ? i_item.x_first : i_item.x_second;
            o_cmd.major_len = w_ady;
            o_cmd.minor_len = w_adx;
            o_cmd.minor_neg = w_fwd ? w_dx[COORD_BITS]
                                    : (w_dx != '0 && !w_dx[COORD_BITS]);
        end else begin
            o_cmd.major_begin = w_fwd ? i_item.x_first : i_item.x_second;
            o_cmd.major_end = w_fwd ? i_item.x_second : i_item.x_first;
            o_cmd.minor_begin = w_fwd ? i_item.y_first : i_item.y_second;
            o_cmd.major_len = w_adx;
            o_cmd.minor_len = w_ady;
            o_cmd.minor_neg = w_fwd ? w_dy[COORD_BITS]
                                    : (w_dy != '0 && !w_dy[COORD_BITS]);
        end
    end

endmodule

// ----- sv/lpg_queue.sv -----
// command queue between front and back, register based
// depends on lpg_pkg
module lpg_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lpg_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output lpg_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_empty
);
    import lpg_pkg::*;

    localparam int PtrBits = $clog2(DEPTH);
    localparam int CntBits = $clog2(DEPTH + 1);

    t_cmd r_mem [DEPTH];
    logic [PtrBits-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrBits-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntBits-1:0] r_count, n_count;
    logic w_push, w_pop;

    assign o_full = (r_count == CntBits'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head = r_mem[r_rd_ptr];
    assign w_push = i_push && !o_full;
    assign w_pop = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PtrBits'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrBits'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntBits'(DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CntBits'(DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

// ----- sv/lpg_back.sv -----
// back end: holds the active line, steps it one pixel per advance command,
// keeps the screen registers and the output register
// depends on lpg_pkg
module lpg_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [lpg_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [lpg_pkg::COORD_BITS-1:0]       i_cfg_data,
    input  lpg_pkg::t_cmd                        i_head,
    input  logic                                 i_empty,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output lpg_pkg::t_out_item                   o_out_data
);
    import lpg_pkg::*;

    logic [COORD_BITS-1:0] r_screen_width;
    logic [COORD_BITS-1:0] r_screen_height;

    logic r_active, n_active;
    logic r_major_is_y;
    logic signed [COORD_BITS-1:0] r_major_cur;
    logic signed [COORD_BITS-1:0] r_major_end;
    logic signed [COORD_BITS-1:0] r_minor_cur;
    logic [COORD_BITS:0] r_two_len;
    logic [COORD_BITS:0] r_two_step;
    logic [REM_BITS-1:0] r_rem;
    logic r_minor_neg;

    logic r_out_valid, n_out_valid;
    t_out_item r_out_data;

    logic w_start, w_adv_fire;
    logic signed [COORD_BITS-1:0] w_px, w_py;
    logic w_off, w_fin;
    logic [REM_BITS-1:0] w_rem_sum;
    logic w_carry;

    assign w_start = !i_empty && (i_head.kind == KIND_START);
    assign o_pop = !i_empty
        && (i_head.kind == KIND_START || !r_active || !r_out_valid || !i_out_stall);
    assign w_adv_fire = o_pop && (i_head.kind == KIND_ADVANCE) && r_active;

    assign w_px = r_major_is_y ? r_minor_cur : r_major_cur;
    assign w_py = r_major_is_y ? r_major_cur : r_minor_cur;
    assign w_off = w_px[COORD_BITS-1] || w_py[COORD_BITS-1]
        || (w_px >= $signed({1'b0, r_screen_width}))
        || (w_py >= $signed({1'b0, r_screen_height}));
    assign w_fin = w_off || (r_major_cur >= r_major_end);

    assign w_rem_sum = r_rem + REM_BITS'(r_two_step);
    assign w_carry = (w_rem_sum >= REM_BITS'(r_two_len));

    always_comb begin
        n_active = r_active;
        if (w_start) begin
            n_active = 1'b1;
        end else if (w_adv_fire && w_fin) begin
            n_active = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_adv_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width <= SCREEN_WIDTH_RESET;
            r_screen_height <= SCREEN_HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH: r_screen_width <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_start) begin
            r_major_is_y <= i_head.major_is_y;
            r_major_cur <= i_head.major_begin;
            r_major_end <= i_head.major_end;
            r_minor_cur <= i_head.minor_begin;
            r_two_len <= {i_head.major_len, 1'b0};
            r_two_step <= {i_head.minor_len, 1'b0};
            r_rem <= REM_BITS'(i_head.major_len);
            r_minor_neg <= i_head.minor_neg;
        end else if (w_adv_fire && !w_fin) begin
            r_major_cur <= r_major_cur + 1'b1;
            if (w_carry) begin
                r_rem <= w_rem_sum - REM_BITS'(r_two_len);
                r_minor_cur <= r_minor_neg ? r_minor_cur - 1'b1 : r_minor_cur + 1'b1;
            end else begin
                r_rem <= w_rem_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_fire) begin
            r_out_data.pixel_x <= w_px;
            r_out_data.pixel_y <= w_py;
            r_out_data.off_screen <= w_off;
            r_out_data.last <= w_fin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_two_len != '0) |-> r_rem < REM_BITS'(r_two_len))
        else $error("minor remainder out of range");

    a_major_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_major_cur <= r_major_end)
        else $error("major coordinate past line end");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv_fire && w_fin) |=> !r_active)
        else $error("line still active after last pixel");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_adv_fire)
        else $error("pending result overwritten");

endmodule

// ----- sv/line_pixel_generator.sv -----
// line pixel generator top level: front setup, command queue, back stepper
// path: an accepted transaction is written into the command queue; the back stepper
// takes it from the queue head and registers its pixel in the output register
// throughput: one transaction per cycle while the output is not stalled, set by the back stepper's single update
// reset: i_rst_n synchronous active low; no line active, screen 640 x 480
// depends on lpg_pkg, lpg_front, lpg_queue, lpg_back
module line_pixel_generator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  lpg_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output lpg_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lpg_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [lpg_pkg::COORD_BITS-1:0]     i_cfg_data
);
    import lpg_pkg::*;

    t_cmd w_cmd;
    t_cmd w_head;
    logic w_full, w_empty, w_pop;

    assign o_in_stall = w_full;
    assign o_cfg_ready = 1'b1;

    lpg_front u_front (
        .i_item (i_in_data),
        .o_cmd  (w_cmd)
    );

    lpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    lpg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
